@@ rtl/dllm_pkg.sv @@
// shared types and codes for the doubly linked list manager
// link format, operation modes and internal operation kinds
// no dependencies
`default_nettype none

package dllm_pkg;

    localparam int NODE_W    = 4;
    localparam int MODE_W    = 3;
    localparam int CNT_OUT_W = 5;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] idx;
    } link_t;

    localparam link_t NIL_LINK = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR      = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_PUSH_FRONT = 3'd2,
        MODE_INS_AFTER  = 3'd3,
        MODE_INS_BEFORE = 3'd4,
        MODE_DELETE     = 3'd5,
        MODE_QUERY      = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_ONLY   = 3'd2,
        OP_AFTER  = 3'd3,
        OP_BEFORE = 3'd4,
        OP_UNLINK = 3'd5
    } op_t;

endpackage

`default_nettype wire

@@ rtl/doubly_linked_list_manager.sv @@
// doubly linked list manager: next and previous links in two memories
// with a sequencer doing read, write back and final link read per transaction
// depends on dllm_pkg
//
// channel  dir  tdata fields (lsb first)
// s_       in   mode[2:0] node_index[6:3] new_node_index[10:7], zero pad to 16
// m_       out  head_node head_valid tail_node tail_valid node_count
//               following_node following_valid preceding_node preceding_valid, pad to 32
//
// each transaction steps through link read, write-back, final link read and
// output load; a splice of a new node beside a listed node has two write-back
// steps, as the single write port per memory sets, and other ops have one
// synchronous reset clears head, tail, count and the per-entry written flags
// a result waiting on m_tready holds the sequencer before its output load
`default_nettype none

module doubly_linked_list_manager
    import dllm_pkg::*;
#(
    parameter int POOL_NODES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // mode, node_index, new_node_index
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // head_node, head_valid, tail_node,
                                                 // tail_valid, node_count, following_node,
                                                 // following_valid, preceding_node,
                                                 // preceding_valid
);

    localparam int DEPTH = (POOL_NODES < (1 << NODE_W)) ? POOL_NODES : (1 << NODE_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(POOL_NODES + 1);
    localparam logic [10:0]      POOL_L  = 11'(POOL_NODES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(POOL_NODES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_W1   = 5'b00010,
        S_W2   = 5'b00100,
        S_RD   = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    function automatic logic in_pool(input logic [NODE_W-1:0] idx);
        return {7'b0, idx} < POOL_L;
    endfunction

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [NODE_W-1:0]  ref_reg, ref_next;
    logic [NODE_W-1:0]  new_reg, new_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic               node_ok_reg, node_ok_next;
    link_t              head_reg, head_next;
    link_t              tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    link_t              next_mem [DEPTH];
    link_t              prev_mem [DEPTH];
    logic [DEPTH-1:0]   next_wr_reg;
    logic [DEPTH-1:0]   prev_wr_reg;
    link_t              rd_next_reg, rd_prev_reg;
    logic               rd_next_ok_reg, rd_prev_ok_reg;

    logic               nx_we, pv_we, rd_en;
    logic [AW-1:0]      nx_wa, pv_wa, rd_addr;
    link_t              nx_wd, pv_wd;

    logic [MODE_W-1:0]  in_mode;
    logic [NODE_W-1:0]  in_node, in_new;
    op_t                dec_op;
    logic [NODE_W-1:0]  dec_ref, dec_new;

    link_t              rd_next_eff, rd_prev_eff;
    logic [CNT_W-1:0]   cnt_up, cnt_down;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
    logic               fv, pv, hv, tv;
    logic [NODE_W-1:0]  f_idx, p_idx, h_idx, t_idx;

    assign in_mode = s_tdata[2:0];
    assign in_node = s_tdata[6:3];
    assign in_new  = s_tdata[10:7];

    // map the requested mode onto a link operation around a reference node
    always_comb begin
        dec_op  = OP_NONE;
        dec_ref = in_node;
        dec_new = in_node;
        unique case (in_mode)
            MODE_CLEAR: begin
                dec_op = OP_CLEAR;
            end
            MODE_PUSH_BACK: begin
                if (in_pool(in_node)) begin
                    if (tail_reg.valid) begin
                        dec_op  = OP_AFTER;
                        dec_ref = tail_reg.idx;
                    end else begin
                        dec_op = OP_ONLY;
                    end
                end
            end
            MODE_PUSH_FRONT: begin
                if (in_pool(in_node)) begin
                    if (head_reg.valid) begin
                        dec_op  = OP_BEFORE;
                        dec_ref = head_reg.idx;
                    end else begin
                        dec_op = OP_ONLY;
                    end
                end
            end
            MODE_INS_AFTER: begin
                if (in_pool(in_node) && in_pool(in_new)) begin
                    dec_op  = OP_AFTER;
                    dec_new = in_new;
                end
            end
            MODE_INS_BEFORE: begin
                if (in_pool(in_node) && in_pool(in_new)) begin
                    dec_op  = OP_BEFORE;
                    dec_new = in_new;
                end
            end
            MODE_DELETE: begin
                if (in_pool(in_node)) begin
                    dec_op = OP_UNLINK;
                end
            end
            default: begin
                dec_op = OP_NONE;
            end
        endcase
    end

    assign rd_next_eff = rd_next_ok_reg ? rd_next_reg : NIL_LINK;
    assign rd_prev_eff = rd_prev_ok_reg ? rd_prev_reg : NIL_LINK;
    assign cnt_up      = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_W'(1);
    assign cnt_down    = (count_reg == '0) ? count_reg : count_reg - CNT_W'(1);

    assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_reg};
    assign hv      = head_reg.valid;
    assign tv      = tail_reg.valid;
    assign fv      = node_ok_reg && rd_next_eff.valid;
    assign pv      = node_ok_reg && rd_prev_eff.valid;
    assign h_idx   = hv ? head_reg.idx : '0;
    assign t_idx   = tv ? tail_reg.idx : '0;
    assign f_idx   = fv ? rd_next_eff.idx : '0;
    assign p_idx   = pv ? rd_prev_eff.idx : '0;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        ref_next      = ref_reg;
        new_next      = new_reg;
        node_next     = node_reg;
        node_ok_next  = node_ok_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        nx_we         = 1'b0;
        nx_wa         = ref_reg[AW-1:0];
        nx_wd         = NIL_LINK;
        pv_we         = 1'b0;
        pv_wa         = ref_reg[AW-1:0];
        pv_wd         = NIL_LINK;
        rd_en         = 1'b0;
        rd_addr       = dec_ref[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = dec_op;
                    ref_next     = dec_ref;
                    new_next     = dec_new;
                    node_next    = in_node;
                    node_ok_next = in_pool(in_node);
                    rd_en        = 1'b1;
                    rd_addr      = dec_ref[AW-1:0];
                    state_next   = S_W1;
                end
            end
            S_W1: begin
                unique case (op_reg)
                    OP_CLEAR: begin
                        head_next  = NIL_LINK;
                        tail_next  = NIL_LINK;
                        count_next = '0;
                    end
                    OP_ONLY: begin
                        nx_we      = 1'b1;
                        nx_wa      = new_reg[AW-1:0];
                        pv_we      = 1'b1;
                        pv_wa      = new_reg[AW-1:0];
                        head_next  = '{valid: 1'b1, idx: new_reg};
                        tail_next  = '{valid: 1'b1, idx: new_reg};
                        count_next = cnt_up;
                    end
                    OP_AFTER: begin
                        if (rd_next_eff.valid) begin
                            pv_we = 1'b1;
                            pv_wa = rd_next_eff.idx[AW-1:0];
                            pv_wd = '{valid: 1'b1, idx: new_reg};
                        end else begin
                            tail_next = '{valid: 1'b1, idx: new_reg};
                        end
                        nx_we = 1'b1;
                        nx_wa = new_reg[AW-1:0];
                        nx_wd = rd_next_eff;
                    end
                    OP_BEFORE: begin
                        if (rd_prev_eff.valid) begin
                            nx_we = 1'b1;
                            nx_wa = rd_prev_eff.idx[AW-1:0];
                            nx_wd = '{valid: 1'b1, idx: new_reg};
                        end else begin
                            head_next = '{valid: 1'b1, idx: new_reg};
                        end
                        pv_we = 1'b1;
                        pv_wa = new_reg[AW-1:0];
                        pv_wd = rd_prev_eff;
                    end
                    OP_UNLINK: begin
                        if (rd_prev_eff.valid) begin
                            nx_we = 1'b1;
                            nx_wa = rd_prev_eff.idx[AW-1:0];
                            nx_wd = rd_next_eff;
                        end else begin
                            head_next = rd_next_eff;
                        end
                        if (rd_next_eff.valid) begin
                            pv_we = 1'b1;
                            pv_wa = rd_next_eff.idx[AW-1:0];
                            pv_wd = rd_prev_eff;
                        end else begin
                            tail_next = rd_prev_eff;
                        end
                        count_next = cnt_down;
                    end
                    default: begin
                    end
                endcase
                state_next = (op_reg == OP_AFTER || op_reg == OP_BEFORE) ? S_W2 : S_RD;
            end
            S_W2: begin
                // second half of a splice: link the new node and the reference node
                nx_we      = 1'b1;
                pv_we      = 1'b1;
                count_next = cnt_up;
                if (op_reg == OP_AFTER) begin
                    pv_wa = new_reg[AW-1:0];
                    pv_wd = '{valid: 1'b1, idx: ref_reg};
                    nx_wa = ref_reg[AW-1:0];
                    nx_wd = '{valid: 1'b1, idx: new_reg};
                end else begin
                    nx_wa = new_reg[AW-1:0];
                    nx_wd = '{valid: 1'b1, idx: ref_reg};
                    pv_wa = ref_reg[AW-1:0];
                    pv_wd = '{valid: 1'b1, idx: new_reg};
                end
                state_next = S_RD;
            end
            S_RD: begin
                rd_en      = 1'b1;
                rd_addr    = node_reg[AW-1:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, pv, p_idx, fv, f_idx, cnt_ext[CNT_OUT_W-1:0],
                                     tv, t_idx, hv, h_idx};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= NIL_LINK;
            tail_reg     <= NIL_LINK;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            next_wr_reg  <= '0;
            prev_wr_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (nx_we) begin
                next_wr_reg[nx_wa] <= 1'b1;
            end
            if (pv_we) begin
                prev_wr_reg[pv_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        ref_reg     <= ref_next;
        new_reg     <= new_next;
        node_reg    <= node_next;
        node_ok_reg <= node_ok_next;
        m_tdata_reg <= m_tdata_next;
    end

    // link memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (rd_en) begin
            rd_next_reg    <= next_mem[rd_addr];
            rd_next_ok_reg <= next_wr_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pv_we) begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (rd_en) begin
            rd_prev_reg    <= prev_mem[rd_addr];
            rd_prev_ok_reg <= prev_wr_reg[rd_addr];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
